// File: sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and round transforms for the AES core.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int MAX_ROUNDS = 14;
	localparam int NUM_RKEYS  = MAX_ROUNDS + 1;

	// register indexes of the configuration port
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_W0   = 3'd1;
	localparam logic [2:0] REG_KEY_W3   = 3'd4;

	// commands
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	// key sizes; the spare code runs as a 256-bit key
	localparam logic [1:0] KS_128  = 2'd0;
	localparam logic [1:0] KS_192  = 2'd1;
	localparam logic [1:0] KS_256  = 2'd2;
	localparam logic [1:0] KS_RSVD = 2'd3;

	// control that travels with a block through the pipeline
	typedef struct packed {
		logic valid;
		logic dec;
	} ctrl_t;

	// what a stage does with the block
	typedef struct packed {
		logic last;   // final round: no column mix
		logic skip;   // past the round count: pass through
	} round_sel_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// forward column mix of one 32-bit column, byte 0 on top
	function automatic logic [31:0] mix_col(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3, t;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		t = a0 ^ a1 ^ a2 ^ a3;
		mix_col = {a0 ^ t ^ xt(a0 ^ a1), a1 ^ t ^ xt(a1 ^ a2),
			a2 ^ t ^ xt(a2 ^ a3), a3 ^ t ^ xt(a3 ^ a0)};
	endfunction

	// inverse column mix: coefficients 0e 0b 0d 09 built from x2, x4, x8
	function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
		logic [7:0] a [4];
		logic [7:0] m2 [4];
		logic [7:0] m4 [4];
		logic [7:0] m8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int k = 0; k < 4; k++) begin
			a[k]  = w[31-8*k -: 8];
			m2[k] = xt(a[k]);
			m4[k] = xt(m2[k]);
			m8[k] = xt(m4[k]);
			m9[k] = m8[k] ^ a[k];
			mb[k] = m8[k] ^ m2[k] ^ a[k];
			md[k] = m8[k] ^ m4[k] ^ a[k];
			me[k] = m8[k] ^ m4[k] ^ m2[k];
		end
		inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
			m9[0] ^ me[1] ^ mb[2] ^ md[3],
			md[0] ^ m9[1] ^ me[2] ^ mb[3],
			mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction

	// byte n of the state is at bits 127-8n; byte r+4c is row r, column c
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] n;
		n = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				n[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
			end
		end
		sub_shift = n;
	endfunction

	function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
		logic [127:0] n;
		n = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				n[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
			end
		end
		inv_sub_shift = n;
	endfunction

	function automatic logic [127:0] mix_state(input logic [127:0] s);
		logic [127:0] n;
		for (int c = 0; c < 4; c++) begin
			n[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
		end
		mix_state = n;
	endfunction

	function automatic logic [127:0] inv_mix_state(input logic [127:0] s);
		logic [127:0] n;
		for (int c = 0; c < 4; c++) begin
			n[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
		end
		inv_mix_state = n;
	endfunction

endpackage

// File: sv/aes_block_cipher_core.sv
// ----------------------------------------------------------------------------
// AES block cipher core
// AES-128/192/256 encrypt and decrypt, one round per pipeline stage, with a
// key expander that fills encryption and equivalent-inverse round keys.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+-------------------
//  block in  | start, busy, command, block_high/low      | start && !busy
//  result    | result_valid, result_high/low             | result_valid
//  config    | cfg_write, cfg_index, cfg_data            | cfg_write
//
//  One block can enter every cycle while busy is low; the result passes through
//  the key-add stage and fourteen round stages (shorter keys pass
//  through the unused stages). After a key write, busy stays high while the
//  expander makes one key word per cycle and then one decrypt round key per
//  cycle. Reset clears control and the key registers; the round keys hold
//  no value until a key is written.
//
module aes_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        result_valid,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import aes_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXP  = 2'd1;
	localparam logic [1:0] ST_INV  = 2'd2;

	// configuration and round key storage
	logic [1:0]   key_size_q;
	logic [63:0]  key_q [4];
	logic [127:0] ek_q [NUM_RKEYS];
	logic [127:0] dk_q [NUM_RKEYS];

	// expander control
	logic [1:0]   phase_q;
	logic [5:0]   i_q;
	logic [2:0]   j_q;
	logic [3:0]   r_q;
	logic [7:0]   rc_q;
	logic [31:0]  win_q [8];

	logic [3:0]   nk;
	logic [3:0]   nr;
	logic [5:0]   total;
	logic [63:0]  kw;
	logic [31:0]  tmp;
	logic [31:0]  new_w;
	logic [127:0] src;
	logic [127:0] inv_src;

	// key geometry
	always_comb begin
		if (key_size_q == KS_128) begin
			nk = 4'd4;
		end else if (key_size_q == KS_192) begin
			nk = 4'd6;
		end else begin
			nk = 4'd8;
		end
		nr    = nk + 4'd6;
		total = {nr, 2'b00} + 6'd4;
	end

	// next expanded key word
	always_comb begin
		kw  = key_q[i_q[2:1]];
		tmp = win_q[0];
		if (j_q == 3'd0) begin
			tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc_q, 24'h0};
		end else if (nk == 4'd8 && j_q == 3'd4) begin
			tmp = sub_word(tmp);
		end
		if (i_q < {2'b00, nk}) begin
			new_w = i_q[0] ? kw[31:0] : kw[63:32];
		end else begin
			new_w = win_q[3'(nk - 4'd1)] ^ tmp;
		end
	end

	// decrypt round key from the mirrored encrypt round
	always_comb begin
		src     = ek_q[nr - r_q];
		inv_src = (r_q == 4'd0 || r_q == nr) ? src : inv_mix_state(src);
	end

	// configuration registers and expander sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ST_IDLE;
			key_size_q <= KS_128;
			key_q      <= '{default: '0};
			i_q        <= '0;
			j_q        <= '0;
			r_q        <= '0;
			rc_q       <= 8'h01;
		end else begin
			if (cfg_write && cfg_index <= REG_KEY_W3) begin
				if (cfg_index == REG_KEY_SIZE) begin
					key_size_q <= cfg_data[1:0];
				end else begin
					key_q[2'(cfg_index - REG_KEY_W0)] <= cfg_data;
				end
				phase_q <= ST_EXP;
				i_q     <= '0;
				j_q     <= '0;
				rc_q    <= 8'h01;
			end else begin
				case (phase_q)
					ST_EXP: begin
						if (i_q >= {2'b00, nk}) begin
							j_q <= (j_q == 3'(nk - 4'd1)) ? 3'd0 : j_q + 3'd1;
							if (j_q == 3'd0) begin
								rc_q <= xt(rc_q);
							end
						end
						if (i_q == total - 6'd1) begin
							phase_q <= ST_INV;
							r_q     <= '0;
						end
						i_q <= i_q + 6'd1;
					end
					ST_INV: begin
						if (r_q == nr) begin
							phase_q <= ST_IDLE;
						end
						r_q <= r_q + 4'd1;
					end
					default: begin
						phase_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// round key stores
	always_ff @(posedge clk) begin
		if (!(cfg_write && cfg_index <= REG_KEY_W3) && phase_q == ST_EXP) begin
			ek_q[i_q[5:2]][127-32*i_q[1:0] -: 32] <= new_w;
			win_q[0] <= new_w;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
		if (!(cfg_write && cfg_index <= REG_KEY_W3) && phase_q == ST_INV) begin
			dk_q[r_q] <= inv_src;
		end
	end

	assign busy = (phase_q != ST_IDLE);

	// pipeline
	ctrl_t        stg_ctrl  [NUM_RKEYS];
	logic [127:0] stg_state [NUM_RKEYS];
	ctrl_t        ctrl_s0;
	logic [127:0] state_s0;

	// first key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s0 <= '0;
		end else begin
			ctrl_s0.valid <= start && !busy;
			ctrl_s0.dec   <= command;
		end
	end

	always_ff @(posedge clk) begin
		state_s0 <= {block_high, block_low} ^
			((command == CMD_DECRYPT) ? dk_q[0] : ek_q[0]);
	end

	assign stg_ctrl[0]  = ctrl_s0;
	assign stg_state[0] = state_s0;

	for (genvar r = 1; r < NUM_RKEYS; r++) begin : g_round
		round_sel_t sel;
		assign sel.last = (nr == 4'(r));
		assign sel.skip = (nr < 4'(r));
		aes_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_ctrl   (stg_ctrl[r-1]),
			.in_state  (stg_state[r-1]),
			.sel       (sel),
			.enc_key   (ek_q[r]),
			.dec_key   (dk_q[r]),
			.out_ctrl  (stg_ctrl[r]),
			.out_state (stg_state[r])
		);
	end

	assign result_valid = stg_ctrl[NUM_RKEYS-1].valid;
	assign result_high  = stg_state[NUM_RKEYS-1][127:64];
	assign result_low   = stg_state[NUM_RKEYS-1][63:0];

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##15 result_valid)
		else $error("accepted block did not come out after 15 cycles");

	a_key_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && cfg_index <= REG_KEY_W3) |=> busy)
		else $error("key write did not start expansion");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ST_EXP) |-> (i_q < total))
		else $error("expander word index out of range");

	a_inv_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ST_INV) |-> (r_q <= nr))
		else $error("decrypt key index out of range");

endmodule

// File: sv/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered pipeline stage: a full round, the final round, or a bypass.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic                clk,
	input  logic                arst_n,
	input  aes_pkg::ctrl_t      in_ctrl,
	input  logic [127:0]        in_state,
	input  aes_pkg::round_sel_t sel,
	input  logic [127:0]        enc_key,
	input  logic [127:0]        dec_key,
	output aes_pkg::ctrl_t      out_ctrl,
	output logic [127:0]        out_state
);
	import aes_pkg::*;

	logic [127:0] sb;
	logic [127:0] mx;
	logic [127:0] rkey;
	logic [127:0] nxt;
	ctrl_t        ctrl_q;
	logic [127:0] state_q;

	// substitute and shift, mix, add round key
	always_comb begin
		sb   = (in_ctrl.dec == CMD_DECRYPT) ? inv_sub_shift(in_state) : sub_shift(in_state);
		mx   = (in_ctrl.dec == CMD_DECRYPT) ? inv_mix_state(sb) : mix_state(sb);
		rkey = (in_ctrl.dec == CMD_DECRYPT) ? dec_key : enc_key;
		if (sel.skip) begin
			nxt = in_state;
		end else if (sel.last) begin
			nxt = sb ^ rkey;
		end else begin
			nxt = mx ^ rkey;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= in_ctrl;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		state_q <= nxt;
	end

	assign out_ctrl  = ctrl_q;
	assign out_state = state_q;

endmodule
